FILE: design/jlg_pkg.sv
// Shared types and constants for the Jacobi Laplace grid solver.
package jlg_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int GRID_MAX_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// Command codes of an input item
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
	localparam logic [1:0] CFG_MAX_ITER  = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE = 2'd2;

	// Configuration reset values
	localparam logic [6:0]  GRID_SIZE_RST = 7'd64;
	localparam logic [15:0] MAX_ITER_RST  = 16'd1000;
	localparam logic [30:0] TOLERANCE_RST = 31'd1;

	// Largest reportable change
	localparam logic [30:0] CHANGE_SAT = 31'h7FFF_FFFF;

	// One input item
	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] cell_value;
	} jlg_req_t;

	// One result item
	typedef struct packed {
		logic signed [31:0] read_value;
		logic [15:0]        sweeps_done;
		logic [30:0]        final_change;
		logic               status;
	} jlg_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic host_acc;    // item transfer this cycle
		logic run_start;   // clear the sweep counter
		logic commit_zero; // run with no sweep
		logic scan_go;     // start one sweep
		logic count_inc;   // one sweep finished
		logic commit;      // latch run result
	} jlg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic zero_iter;  // iteration limit is zero
		logic scan_idle;  // no sweep in flight
		logic within_tol; // largest change at most the tolerance
		logic last_iter;  // the sweep just done reaches the limit
	} jlg_stat_t;

endpackage

FILE: design/jacobi_laplace_grid_solver_core.sv
// Top level of the Jacobi Laplace grid solver: configuration registers, controller, datapath.
//
//  channel   direction  signals                           transfer
//  -------   ---------  --------------------------------  ---------------------------
//  item      in         start, request, busy              edge with start high, busy low
//  result    out        done, result                      every cycle done is high
//  config    in         cfg_we, cfg_index, cfg_wdata      edge with cfg_we high
//
// Cell writes and reads leave busy low: the result strobe follows the transfer in the
// next cycle, so such items can be given every cycle.
// A run holds busy high; each sweep streams the grid through the single memory read port
// in raster order, rows 0 to n-1 with n the grid side in use; grids smaller than 3 skip
// the scan. The result follows the last sweep through the evaluation state.
// Reset clears control and the run results; the grid memory holds nothing defined until
// written. The receiver cannot stall: each result is flagged by done for one cycle only.
module jacobi_laplace_grid_solver_core
	import jlg_pkg::*;
#(
	parameter int GRID_MAX    = GRID_MAX_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  jlg_req_t    request,
	output logic        done,
	output jlg_rsp_t    result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_wdata
);

	localparam int NW = $clog2(GRID_MAX + 1);

	logic [6:0]    grid_size_q;
	logic [15:0]   max_iter_q;
	logic [30:0]   tolerance_q;
	logic [NW-1:0] n_eff;
	jlg_cmd_t      cmd;
	jlg_stat_t     stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RST;
			max_iter_q  <= MAX_ITER_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE: grid_size_q <= cfg_wdata[6:0];
				CFG_MAX_ITER:  max_iter_q  <= cfg_wdata[15:0];
				CFG_TOLERANCE: tolerance_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Grid side in use, limited by storage
	assign n_eff = (int'(grid_size_q) < GRID_MAX) ? NW'(grid_size_q) : NW'(GRID_MAX);

	jlg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	jlg_datapath #(
		.GRID_MAX    (GRID_MAX),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.n_eff     (n_eff),
		.max_iter  (max_iter_q),
		.tolerance (tolerance_q),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

FILE: design/jlg_ctrl.sv
// Sequencing state machine for host transfers and sweep runs.
module jlg_ctrl
	import jlg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  jlg_stat_t  stat,
	output jlg_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN_GO,
		S_SCAN_WAIT,
		S_EVAL
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   acc;
	logic   is_run;
	logic   stop;

	assign acc    = start && !busy_q;
	assign is_run = (command == CMD_RUN);
	assign stop   = stat.within_tol || stat.last_iter;

	// Command decode
	always_comb begin
		cmd             = '0;
		cmd.host_acc    = (state_q == S_IDLE) && acc;
		cmd.run_start   = (state_q == S_IDLE) && acc && is_run;
		cmd.commit_zero = (state_q == S_IDLE) && acc && is_run && stat.zero_iter;
		cmd.scan_go     = (state_q == S_SCAN_GO);
		cmd.count_inc   = (state_q == S_EVAL);
		cmd.commit      = (state_q == S_EVAL) && stop;
	end

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (is_run && !stat.zero_iter) begin
							state_q <= S_SCAN_GO;
							busy_q  <= 1'b1;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SCAN_GO: begin
					state_q <= S_SCAN_WAIT;
				end
				S_SCAN_WAIT: begin
					if (stat.scan_idle)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stop) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_SCAN_GO;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: design/jlg_datapath.sv
// Grid memory, raster sweep pipeline with stencil window, change tracking, results.
module jlg_datapath
	import jlg_pkg::*;
#(
	parameter int GRID_MAX    = GRID_MAX_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jlg_req_t                       request,
	input  logic [$clog2(GRID_MAX+1)-1:0]  n_eff,
	input  logic [15:0]                    max_iter,
	input  logic [30:0]                    tolerance,
	input  jlg_cmd_t                       cmd,
	output jlg_stat_t                      stat,
	output jlg_rsp_t                       result
);

	localparam int VW    = VALUE_WIDTH;
	localparam int NW    = $clog2(GRID_MAX + 1);
	localparam int RW    = $clog2(GRID_MAX);
	localparam int AW    = $clog2(GRID_MAX * GRID_MAX);
	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int TAPS  = 2 * GRID_MAX + 1;
	localparam int MW    = (VW + 1 > 31) ? VW + 1 : 31;
	localparam int HW    = NW + 6;

	// Grid storage
	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rdata_q;

	// Scan counters
	logic          scan_act_q;
	logic [RW-1:0] scan_row_q;
	logic [RW-1:0] scan_col_q;
	logic [AW-1:0] scan_addr_q;

	// Pipeline
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [RW-1:0] row_s1, row_s2;
	logic [RW-1:0] col_s1, col_s2;
	logic [AW-1:0] addr_s1, addr_s2;
	logic          we_s3, we_s4;
	logic [VW-1:0] nv_s3, old_s3;
	logic [AW-1:0] waddr_s3;
	logic [VW:0]   diff_s4;
	logic [VW-1:0] taps_q [TAPS];

	// Run state and results
	logic [VW:0]   maxd_q;
	logic [15:0]   iter_q;
	logic [15:0]   sweep_cnt_q;
	logic [30:0]   change_q;
	logic          rd_sel_q;
	logic          status_q;

	// Host side
	logic          in_range;
	logic [AW-1:0] host_addr;
	logic          host_we;
	logic [VW-1:0] host_wdata;

	// Memory port selection
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [VW-1:0] mem_wdata;

	// Stencil arithmetic
	logic signed [VW+1:0] sum4;
	logic                 interior_s2;
	logic [NW:0]          r_ext, c_ext, n_ext;
	logic signed [VW:0]   delta;
	logic [VW:0]          abs_delta;
	logic                 scan_end;

	assign in_range  = (HW'(request.row) < HW'(n_eff)) && (HW'(request.col) < HW'(n_eff));
	assign host_addr = AW'(AW'(request.row) * AW'(GRID_MAX) + AW'(request.col));
	assign host_we   = cmd.host_acc && (request.command == CMD_WRITE) && in_range;
	assign host_wdata = VW'($signed(request.cell_value));

	assign rd_addr   = scan_act_q ? scan_addr_q : host_addr;
	assign mem_we    = we_s3 || host_we;
	assign mem_waddr = we_s3 ? waddr_s3 : host_addr;
	assign mem_wdata = we_s3 ? nv_s3 : host_wdata;

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[rd_addr];
	end

	assign scan_end = (scan_row_q == RW'(n_eff - NW'(1))) &&
	                  (scan_col_q == RW'(GRID_MAX - 1));

	// Raster scan over rows 0..n-1, every column of the stride
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q  <= 1'b0;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			scan_addr_q <= '0;
		end else if (cmd.scan_go) begin
			scan_act_q  <= (n_eff >= NW'(3));
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			scan_addr_q <= '0;
		end else if (scan_act_q) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			if (scan_end)
				scan_act_q <= 1'b0;
			if (scan_col_q == RW'(GRID_MAX - 1)) begin
				scan_col_q <= '0;
				scan_row_q <= scan_row_q + RW'(1);
			end else begin
				scan_col_q <= scan_col_q + RW'(1);
			end
		end
	end

	// Valid bits of the sweep pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			we_s3 <= 1'b0;
			we_s4 <= 1'b0;
		end else begin
			v_s1  <= scan_act_q;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			we_s3 <= v_s2 && interior_s2;
			we_s4 <= we_s3;
		end
	end

	// Window shift line: tap k holds the cell k places behind the newest read
	always_ff @(posedge clk) begin
		if (v_s1) begin
			taps_q[0] <= rdata_q;
			for (int k = 1; k < TAPS; k++)
				taps_q[k] <= taps_q[k-1];
		end
	end

	// Centre of the window is one row behind the newest read
	assign r_ext = (NW+1)'(row_s2);
	assign c_ext = (NW+1)'(col_s2);
	assign n_ext = (NW+1)'(n_eff);
	assign interior_s2 = (r_ext >= (NW+1)'(2)) && (r_ext + (NW+1)'(1) <= n_ext) &&
	                     (c_ext >= (NW+1)'(1)) && (c_ext + (NW+1)'(2) <= n_ext);

	// Four-neighbour sum, floor by arithmetic shift
	assign sum4 = (VW+2)'($signed(taps_q[0])) +
	              (VW+2)'($signed(taps_q[GRID_MAX-1])) +
	              (VW+2)'($signed(taps_q[GRID_MAX+1])) +
	              (VW+2)'($signed(taps_q[2*GRID_MAX]));

	assign delta     = (VW+1)'($signed(nv_s3)) - (VW+1)'($signed(old_s3));
	assign abs_delta = delta[VW] ? (VW+1)'(-delta) : (VW+1)'(delta);

	// Pipeline payload
	always_ff @(posedge clk) begin
		row_s1   <= scan_row_q;
		col_s1   <= scan_col_q;
		addr_s1  <= scan_addr_q;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		addr_s2  <= addr_s1;
		nv_s3    <= sum4[VW+1:2];
		old_s3   <= taps_q[GRID_MAX];
		waddr_s3 <= addr_s2 - AW'(GRID_MAX);
		diff_s4  <= abs_delta;
	end

	// Largest change of the current sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			maxd_q <= '0;
		else if (cmd.scan_go)
			maxd_q <= '0;
		else if (we_s4 && (diff_s4 > maxd_q))
			maxd_q <= diff_s4;
	end

	// Sweep counter and run results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q      <= '0;
			sweep_cnt_q <= '0;
			change_q    <= '0;
			rd_sel_q    <= 1'b0;
			status_q    <= 1'b0;
		end else begin
			if (cmd.run_start)
				iter_q <= '0;
			else if (cmd.count_inc)
				iter_q <= iter_q + 16'd1;
			if (cmd.commit_zero) begin
				sweep_cnt_q <= '0;
				change_q    <= '0;
			end else if (cmd.commit) begin
				sweep_cnt_q <= iter_q + 16'd1;
				change_q    <= (MW'(maxd_q) > MW'(CHANGE_SAT)) ? CHANGE_SAT : 31'(maxd_q);
			end
			if (cmd.host_acc) begin
				rd_sel_q <= (request.command == CMD_READ) && in_range;
				status_q <= ((request.command == CMD_WRITE) ||
				             (request.command == CMD_READ)) && !in_range;
			end
		end
	end

	// Status to the controller
	always_comb begin
		stat.zero_iter  = (max_iter == 16'd0);
		stat.scan_idle  = !scan_act_q && !v_s1 && !v_s2 && !v_s3 && !v_s4;
		stat.within_tol = (MW'(maxd_q) <= MW'(tolerance));
		stat.last_iter  = ((17'(iter_q) + 17'd1) == 17'(max_iter));
	end

	// Result item
	always_comb begin
		result.read_value   = rd_sel_q ? 32'($signed(rdata_q)) : 32'sd0;
		result.sweeps_done  = sweep_cnt_q;
		result.final_change = change_q;
		result.status       = status_q;
	end

endmodule
